@@ design/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg
// Types and constants shared by the stair climb sequencer modules.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int CFG_W       = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [2:0] {
		CFG_DETECT_DIST    = 3'd0,
		CFG_TOO_CLOSE_DIST = 3'd1,
		CFG_CLIMB_PITCH    = 3'd2,
		CFG_LEVEL_PITCH    = 3'd3,
		CFG_MAX_ATTEMPTS   = 3'd4,
		CFG_CLIMB_TIMEOUT  = 3'd5,
		CFG_SETTLE         = 3'd6,
		CFG_YAW_LIMIT      = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_INIT      = 3'd0,
		PH_APPROACH  = 3'd1,
		PH_CHECK     = 3'd2,
		PH_CLIMB     = 3'd3,
		PH_STABILIZE = 3'd4,
		PH_COMPLETE  = 3'd5
	} phase_t;

	localparam logic [2:0] CMD_STOP  = 3'd0;
	localparam logic [2:0] CMD_FWD   = 3'd1;
	localparam logic [2:0] CMD_BACK  = 3'd2;
	localparam logic [2:0] CMD_LEFT  = 3'd3;
	localparam logic [2:0] CMD_RIGHT = 3'd4;

	localparam logic [7:0] SPD_APPROACH = 8'd180;
	localparam logic [7:0] SPD_FULL     = 8'd255;
	localparam logic [7:0] SPD_STEEP    = 8'd200;
	localparam logic [7:0] SPD_BACK     = 8'd150;
	localparam logic [7:0] SPD_SETTLE   = 8'd150;
	localparam logic [7:0] SPD_TURN     = 8'd100;

	localparam logic [8:0] HOLD_NONE  = 9'd0;
	localparam logic [8:0] HOLD_CHECK = 9'd200;
	localparam logic [8:0] HOLD_BACK  = 9'd300;
	localparam logic [8:0] HOLD_TURN  = 9'd50;

	typedef struct packed {
		logic [8:0] hold_ms;
		logic [7:0] speed;
		logic [2:0] motor_cmd;
	} cmd_t;

	typedef struct packed {
		cmd_t [2:0] cmd;
		logic [1:0] count;
		phase_t     phase;
	} bundle_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic signed [15:0] yaw_dev;
		logic signed [15:0] pitch;
		logic [13:0]        distance;
	} step_t;

	typedef struct packed {
		logic [13:0] detect_distance;
		logic [13:0] too_close_distance;
		logic [14:0] climb_pitch;
		logic [14:0] level_pitch;
		logic [2:0]  max_attempts;
		logic [15:0] climb_timeout_ms;
		logic [15:0] settle_ms;
		logic [14:0] yaw_limit;
	} cfg_t;

	function automatic cmd_t mk_cmd(logic [2:0] c, logic [7:0] s, logic [8:0] h);
		cmd_t r;
		r.motor_cmd = c;
		r.speed     = s;
		r.hold_ms   = h;
		return r;
	endfunction

endpackage

@@ design/scs_front.sv @@
// ----------------------------------------------------------------------------
// scs_front
// Phase state, configuration registers and per-step command bundle builder.
// ----------------------------------------------------------------------------
module scs_front #(
	parameter int TIME_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  scs_pkg::cfg_idx_t        cfg_index,
	input  logic [scs_pkg::CFG_W-1:0] cfg_data,
	input  logic                     accept,
	input  scs_pkg::step_t           step,
	output logic                     push,
	output scs_pkg::bundle_t         bundle
);
	import scs_pkg::*;

	cfg_t                 cfg_q;
	phase_t               phase_q, phase_d;
	logic [TIME_BITS-1:0] start_q, start_d;
	logic [2:0]           att_q, att_d;

	logic [TIME_BITS-1:0] now_t, clk_chk, clk_clb, elapsed_clb, elapsed_stb;
	logic signed [16:0]   pitch_x, yaw_x, climb_x, level_x, ylim_x;
	logic                 steep, turn_l, turn_r, leave, timeout, settled, close;
	logic [2:0]           att_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detect_distance    <= 14'd150;
			cfg_q.too_close_distance <= 14'd50;
			cfg_q.climb_pitch        <= 15'd1500;
			cfg_q.level_pitch        <= 15'd500;
			cfg_q.max_attempts       <= 3'd3;
			cfg_q.climb_timeout_ms   <= 16'd10000;
			cfg_q.settle_ms          <= 16'd1000;
			cfg_q.yaw_limit          <= 15'd300;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DETECT_DIST:    cfg_q.detect_distance    <= cfg_data[13:0];
				CFG_TOO_CLOSE_DIST: cfg_q.too_close_distance <= cfg_data[13:0];
				CFG_CLIMB_PITCH:    cfg_q.climb_pitch        <= cfg_data[14:0];
				CFG_LEVEL_PITCH:    cfg_q.level_pitch        <= cfg_data[14:0];
				CFG_MAX_ATTEMPTS:   cfg_q.max_attempts       <= cfg_data[2:0];
				CFG_CLIMB_TIMEOUT:  cfg_q.climb_timeout_ms   <= cfg_data[15:0];
				CFG_SETTLE:         cfg_q.settle_ms          <= cfg_data[15:0];
				CFG_YAW_LIMIT:      cfg_q.yaw_limit          <= cfg_data[14:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INIT;
			start_q <= '0;
			att_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			start_q <= start_d;
			att_q   <= att_d;
		end
	end

	always_comb begin
		now_t   = TIME_BITS'(step.now_ms);
		pitch_x = 17'(step.pitch);
		yaw_x   = 17'(step.yaw_dev);
		climb_x = $signed({2'b00, cfg_q.climb_pitch});
		level_x = $signed({2'b00, cfg_q.level_pitch});
		ylim_x  = $signed({2'b00, cfg_q.yaw_limit});

		close   = step.distance < cfg_q.too_close_distance;
		clk_chk = close ? now_t + TIME_BITS'(HOLD_CHECK) + TIME_BITS'(HOLD_BACK)
		                : now_t + TIME_BITS'(HOLD_CHECK);

		steep   = !(pitch_x < climb_x);
		turn_l  = !steep && (yaw_x > ylim_x);
		turn_r  = !steep && !turn_l && (yaw_x < -ylim_x);
		clk_clb = (turn_l || turn_r) ? now_t + TIME_BITS'(HOLD_TURN) : now_t;
		leave   = (pitch_x < level_x) && (step.distance > cfg_q.detect_distance);
		elapsed_clb = clk_clb - start_q;
		timeout = !leave && (elapsed_clb > TIME_BITS'(cfg_q.climb_timeout_ms));
		att_inc = (att_q == 3'd7) ? att_q : att_q + 3'd1;

		elapsed_stb = now_t - start_q;
		settled     = elapsed_stb > TIME_BITS'(cfg_q.settle_ms);

		phase_d = phase_q;
		start_d = start_q;
		att_d   = att_q;
		bundle.cmd   = '0;
		bundle.count = 2'd0;

		unique case (phase_q)
			PH_INIT: begin
				start_d = now_t;
				att_d   = '0;
				phase_d = PH_APPROACH;
			end
			PH_APPROACH: begin
				bundle.cmd[0] = mk_cmd(CMD_FWD, SPD_APPROACH, HOLD_NONE);
				bundle.count  = 2'd1;
				if (step.distance < cfg_q.detect_distance) begin
					phase_d = PH_CHECK;
					start_d = now_t;
				end
			end
			PH_CHECK: begin
				bundle.cmd[0] = mk_cmd(CMD_STOP, 8'd0, HOLD_CHECK);
				bundle.cmd[1] = mk_cmd(CMD_BACK, SPD_BACK, HOLD_BACK);
				bundle.count  = close ? 2'd2 : 2'd1;
				phase_d = PH_CLIMB;
				start_d = clk_chk;
			end
			PH_CLIMB: begin
				bundle.cmd[0] = mk_cmd(CMD_FWD, steep ? SPD_STEEP : SPD_FULL, HOLD_NONE);
				bundle.count  = 2'd1;
				if (turn_l || turn_r) begin
					bundle.cmd[1] = mk_cmd(turn_l ? CMD_LEFT : CMD_RIGHT, SPD_TURN, HOLD_TURN);
					bundle.count  = 2'd2;
				end
				if (leave) begin
					phase_d = PH_STABILIZE;
					start_d = clk_clb;
				end
				if (timeout) begin
					att_d = att_inc;
					if (att_inc >= cfg_q.max_attempts) begin
						bundle.cmd[bundle.count] = mk_cmd(CMD_STOP, 8'd0, HOLD_NONE);
						bundle.count = bundle.count + 2'd1;
						phase_d = PH_INIT;
					end else begin
						phase_d = PH_CHECK;
					end
				end
			end
			PH_STABILIZE: begin
				bundle.cmd[0] = mk_cmd(CMD_FWD, SPD_SETTLE, HOLD_NONE);
				bundle.cmd[1] = mk_cmd(CMD_STOP, 8'd0, HOLD_NONE);
				bundle.count  = settled ? 2'd2 : 2'd1;
				if (settled)
					phase_d = PH_COMPLETE;
			end
			default: begin
				bundle.cmd[0] = mk_cmd(CMD_STOP, 8'd0, HOLD_NONE);
				bundle.count  = 2'd1;
			end
		endcase

		bundle.phase = phase_d;
		push = accept && (bundle.count != 2'd0);
	end

endmodule

@@ design/scs_queue.sv @@
// ----------------------------------------------------------------------------
// scs_queue
// Short FIFO of command bundles between the front and back parts.
// ----------------------------------------------------------------------------
module scs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  scs_pkg::bundle_t wr_data,
	input  logic             pop,
	output scs_pkg::bundle_t rd_data,
	output logic             full,
	output logic             empty
);
	import scs_pkg::*;

	bundle_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ design/scs_back.sv @@
// ----------------------------------------------------------------------------
// scs_back
// Serializes each queued bundle into motor command requests.
// ----------------------------------------------------------------------------
module scs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  scs_pkg::bundle_t head,
	input  logic             empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output scs_pkg::cmd_t    out_cmd,
	output scs_pkg::phase_t  out_phase,
	output logic             out_last
);
	import scs_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q, last_q, load, final_cmd;
	cmd_t       cmd_q;
	phase_t     phase_q;

	assign load      = !empty && (!valid_q || out_ready);
	assign final_cmd = idx_q == (head.count - 2'd1);
	assign pop       = load && final_cmd;

	assign out_valid = valid_q;
	assign out_cmd   = cmd_q;
	assign out_phase = phase_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_cmd ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q   <= head.cmd[idx_q];
			phase_q <= head.phase;
			last_q  <= final_cmd;
		end
	end

endmodule

@@ design/stair_climb_sequencer.sv @@
// ----------------------------------------------------------------------------
// stair_climb_sequencer
// Phase sequencer for a stair climbing robot: one control step in, up to
// three motor commands out.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: distance, pitch, yaw_dev, now_ms
//  m_      | out | m_tvalid/m_tready  | m_tdata: motor_cmd, speed, hold_ms, phase;
//          |     |                    | m_tlast: last command of a step
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// A step is taken by the front part whenever the four-entry bundle queue has room;
// its commands leave the back part at one per cycle while m_tready is high, so a
// step puts one to three commands on the output and an init step puts none.
// Each command passes through the bundle queue, then the back part's output register.
// Reset clears phase, attempt count, start time, queue and output valid.
// A stalled output fills the queue, then drops s_tready.
// ----------------------------------------------------------------------------
module stair_climb_sequencer #(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // distance[13:0] pitch[29:14] yaw_dev[45:30] now_ms[77:46]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // motor_cmd[2:0] speed[10:3] hold_ms[19:11] phase[22:20]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import scs_pkg::*;

	step_t   step;
	bundle_t wr_bundle, head;
	logic    accept, push, pop, full, empty;
	cmd_t    out_cmd;
	phase_t  out_phase;

	assign step     = s_tdata[77:0];
	assign s_tready = !full;
	assign accept   = s_tvalid && !full;

	scs_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_idx_t'(cfg_index)),
		.cfg_data (cfg_data),
		.accept   (accept),
		.step     (step),
		.push     (push),
		.bundle   (wr_bundle)
	);

	scs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(wr_bundle),
		.pop    (pop),
		.rd_data(head),
		.full   (full),
		.empty  (empty)
	);

	scs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_cmd  (out_cmd),
		.out_phase(out_phase),
		.out_last (m_tlast)
	);

	assign m_tdata = {1'b0, out_phase, out_cmd.hold_ms, out_cmd.speed, out_cmd.motor_cmd};

endmodule

@@ verif/stair_climb_sequencer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stair_climb_sequencer_test
// Self-checking bench for the stair climb sequencer. Control steps go in on
// the s_ stream and motor commands come out on the m_ stream. A scoreboard
// tracks phase, start time and attempt count and checks each command in order.
// A short directed run covers the boundaries and special cases. Steered random
// steps follow under several register settings, ending with the stabilize and
// complete path. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
import scs_pkg::*;

typedef struct packed {
	logic [2:0] cmd;
	logic [7:0] speed;
	logic [8:0] hold;
	phase_t     phase;
	logic       last;
} motor_cmd_t;

typedef logic [15:0] reg_set_t [8];

class climb_scoreboard;
	cfg_t        cfg;
	phase_t      phase;
	logic [31:0] phase_start;
	int unsigned attempts;
	motor_cmd_t  pending_cmds[$];
	motor_cmd_t  step_cmds[$];
	int unsigned mismatches;
	int unsigned cmds_seen;

	function new();
		cfg.detect_distance    = 14'd150;
		cfg.too_close_distance = 14'd50;
		cfg.climb_pitch        = 15'd1500;
		cfg.level_pitch        = 15'd500;
		cfg.max_attempts       = 3'd3;
		cfg.climb_timeout_ms   = 16'd10000;
		cfg.settle_ms          = 16'd1000;
		cfg.yaw_limit          = 15'd300;
		phase       = PH_INIT;
		phase_start = '0;
		attempts    = 0;
		mismatches  = 0;
		cmds_seen   = 0;
	endfunction

	function void set_reg(cfg_idx_t idx, logic [15:0] v);
		case (idx)
			CFG_DETECT_DIST:    cfg.detect_distance    = v[13:0];
			CFG_TOO_CLOSE_DIST: cfg.too_close_distance = v[13:0];
			CFG_CLIMB_PITCH:    cfg.climb_pitch        = v[14:0];
			CFG_LEVEL_PITCH:    cfg.level_pitch        = v[14:0];
			CFG_MAX_ATTEMPTS:   cfg.max_attempts       = v[2:0];
			CFG_CLIMB_TIMEOUT:  cfg.climb_timeout_ms   = v;
			CFG_SETTLE:         cfg.settle_ms          = v;
			default:            cfg.yaw_limit          = v[14:0];
		endcase
	endfunction

	function void issue(logic [2:0] c, logic [7:0] s, logic [8:0] h);
		motor_cmd_t d;
		d.cmd   = c;
		d.speed = s;
		d.hold  = h;
		d.phase = PH_INIT;
		d.last  = 1'b0;
		step_cmds.push_back(d);
	endfunction

	// predict the commands of one accepted request
	function void take_step(step_t st);
		logic [31:0] t;
		logic [31:0] elapsed;
		int          pitch_v;
		int          yaw_v;
		t       = st.now_ms;
		pitch_v = $signed(st.pitch);
		yaw_v   = $signed(st.yaw_dev);
		step_cmds.delete();
		case (phase)
			PH_INIT: begin
				phase_start = t;
				attempts    = 0;
				phase       = PH_APPROACH;
			end
			PH_APPROACH: begin
				issue(CMD_FWD, SPD_APPROACH, HOLD_NONE);
				if (st.distance < cfg.detect_distance) begin
					phase       = PH_CHECK;
					phase_start = t;
				end
			end
			PH_CHECK: begin
				issue(CMD_STOP, 8'd0, HOLD_CHECK);
				t = t + HOLD_CHECK;
				if (st.distance < cfg.too_close_distance) begin
					issue(CMD_BACK, SPD_BACK, HOLD_BACK);
					t = t + HOLD_BACK;
				end
				phase       = PH_CLIMB;
				phase_start = t;
			end
			PH_CLIMB: begin
				if (pitch_v < int'(cfg.climb_pitch)) begin
					issue(CMD_FWD, SPD_FULL, HOLD_NONE);
					if (yaw_v > int'(cfg.yaw_limit)) begin
						issue(CMD_LEFT, SPD_TURN, HOLD_TURN);
						t = t + HOLD_TURN;
					end else if (yaw_v < -int'(cfg.yaw_limit)) begin
						issue(CMD_RIGHT, SPD_TURN, HOLD_TURN);
						t = t + HOLD_TURN;
					end
				end else begin
					issue(CMD_FWD, SPD_STEEP, HOLD_NONE);
				end
				if (pitch_v < int'(cfg.level_pitch) && st.distance > cfg.detect_distance) begin
					phase       = PH_STABILIZE;
					phase_start = t;
				end
				elapsed = t - phase_start;
				if (elapsed > cfg.climb_timeout_ms) begin
					if (attempts < 7)
						attempts++;
					if (attempts >= cfg.max_attempts) begin
						issue(CMD_STOP, 8'd0, HOLD_NONE);
						phase = PH_INIT;
					end else begin
						phase = PH_CHECK;
					end
				end
			end
			PH_STABILIZE: begin
				issue(CMD_FWD, SPD_SETTLE, HOLD_NONE);
				elapsed = t - phase_start;
				if (elapsed > cfg.settle_ms) begin
					issue(CMD_STOP, 8'd0, HOLD_NONE);
					phase = PH_COMPLETE;
				end
			end
			default: issue(CMD_STOP, 8'd0, HOLD_NONE);
		endcase
		foreach (step_cmds[k]) begin
			step_cmds[k].phase = phase;
			step_cmds[k].last  = (k == step_cmds.size() - 1);
			pending_cmds.push_back(step_cmds[k]);
		end
	endfunction

	function void check_cmd(logic [23:0] d, logic l);
		motor_cmd_t e;
		cmds_seen++;
		if (pending_cmds.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected command %0d: cmd %0d speed %0d hold %0d phase %0d last %0d",
					cmds_seen, d[2:0], d[10:3], d[19:11], d[22:20], l);
			return;
		end
		e = pending_cmds.pop_front();
		if (d[2:0] !== e.cmd || d[10:3] !== e.speed || d[19:11] !== e.hold ||
			d[22:20] !== e.phase || l !== e.last) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("command %0d mismatch: expected cmd %0d speed %0d hold %0d phase %0d last %0d",
					cmds_seen, e.cmd, e.speed, e.hold, e.phase, e.last);
				$display("  got cmd %0d speed %0d hold %0d phase %0d last %0d",
					d[2:0], d[10:3], d[19:11], d[22:20], l);
			end
		end
	endfunction
endclass

module stair_climb_sequencer_test;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // distance[13:0] pitch[29:14] yaw_dev[45:30] now_ms[77:46]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // motor_cmd[2:0] speed[10:3] hold_ms[19:11] phase[22:20]
	logic        m_tlast;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	climb_scoreboard sb;
	logic [31:0]     clock_now;
	int unsigned     steps_sent;
	bit              settle_probed;
	bit              stall_done;
	reg_set_t        reg_vals;

	stair_climb_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d commands outstanding", sb.pending_cmds.size());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic step_t step_of(int d, int p, int y, logic [31:0] n);
		step_t st;
		st.distance = 14'(d);
		st.pitch    = 16'(p);
		st.yaw_dev  = 16'(y);
		st.now_ms   = n;
		return st;
	endfunction

	function automatic int near(int v);
		int w;
		w = v + int'($urandom_range(0, 4)) - 2;
		if (w > 18000)
			w = 18000;
		if (w < -18000)
			w = -18000;
		return w;
	endfunction

	function automatic int pick_angle(int a, int b);
		case ($urandom_range(0, 5))
			0: return -18000;
			1: return 18000;
			2: return near(a);
			3: return near(b);
			default: return int'($urandom_range(0, 36000)) - 18000;
		endcase
	endfunction

	// steer fields toward the current phase; keep climb from reaching stabilize unless finishing
	function automatic step_t make_step(bit finish);
		step_t       st;
		int unsigned r;
		r = $urandom_range(0, 99);
		st.distance = 14'($urandom_range(0, 9999));
		st.pitch    = 16'(pick_angle(int'(sb.cfg.climb_pitch), int'(sb.cfg.level_pitch)));
		st.yaw_dev  = 16'(pick_angle(int'(sb.cfg.yaw_limit), -int'(sb.cfg.yaw_limit)));
		clock_now   = clock_now + $urandom_range(0, 1500);
		if (r < 3)
			clock_now = $urandom;
		if (r >= 8 || finish) begin
			case (sb.phase)
				PH_APPROACH: begin
					if (finish || $urandom_range(0, 99) < 35) begin
						if (sb.cfg.detect_distance != 0)
							st.distance = 14'($urandom_range(0, sb.cfg.detect_distance - 1));
					end else if (st.distance < sb.cfg.detect_distance) begin
						st.distance = 14'($urandom_range(sb.cfg.detect_distance, 9999));
					end
				end
				PH_CHECK: begin
					if ($urandom_range(0, 1) == 1 && sb.cfg.too_close_distance != 0)
						st.distance = 14'($urandom_range(0, sb.cfg.too_close_distance - 1));
				end
				PH_CLIMB: begin
					if (finish) begin
						st.pitch    = 16'(-int'($urandom_range(1, 18000)));
						st.distance = 14'($urandom_range(sb.cfg.detect_distance + 1, 9999));
						clock_now   = sb.phase_start + sb.cfg.climb_timeout_ms + 32'd500;
					end else if (r < 38) begin
						clock_now = sb.phase_start + sb.cfg.climb_timeout_ms + $urandom_range(0, 60);
					end
				end
				PH_STABILIZE: begin
					if (!settle_probed) begin
						clock_now     = sb.phase_start + sb.cfg.settle_ms;
						settle_probed = 1'b1;
					end else begin
						clock_now = sb.phase_start + sb.cfg.settle_ms + 1 + $urandom_range(0, 9);
					end
				end
				default: ;
			endcase
		end
		if (sb.phase == PH_CLIMB && !finish && $signed(st.pitch) < int'(sb.cfg.level_pitch) &&
			st.distance > sb.cfg.detect_distance)
			st.distance = 14'($urandom_range(0, sb.cfg.detect_distance));
		st.now_ms = clock_now;
		return st;
	endfunction

	task automatic send_step(step_t st);
		while (!(steps_sent >= 40 && steps_sent < 110) && $urandom_range(0, 99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, st};
		do
			@(posedge clk);
		while (!s_tready);
		sb.take_step(st);
		steps_sent++;
	endtask

	// hold off requests until every command is out, then let the pipeline drain
	task automatic drain_cmds();
		s_tvalid <= 1'b0;
		while (sb.pending_cmds.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_settings(input reg_set_t vals);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= vals[i];
			sb.set_reg(cfg_idx_t'(i), vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_cmd(m_tdata, m_tlast);
	end

	initial begin
		m_tready   = 1'b0;
		stall_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!stall_done && sb.cmds_seen >= 40) begin
				stall_done = 1'b1;
				m_tready <= 1'b0;
				repeat (80) @(posedge clk);
			end else begin
				m_tready <= (sb.cmds_seen >= 150 && sb.cmds_seen < 260) ||
					$urandom_range(0, 99) >= 19;
			end
		end
	end

	initial begin
		sb            = new();
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_DETECT_DIST;
		cfg_data      = '0;
		arst_n        = 1'b0;
		clock_now     = '0;
		steps_sent    = 0;
		settle_probed = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_step(step_of(9999, -18000, 18000, 32'hFFFF_FF00));
		send_step(step_of(9999, 0, 0, 32'hFFFF_FF10));
		send_step(step_of(0, 0, 0, 32'hFFFF_FF20));
		send_step(step_of(0, 0, 0, 32'hFFFF_FF30));
		send_step(step_of(0, 18000, 0, 32'h0000_0200));
		send_step(step_of(0, -18000, 18000, 32'h0000_0300));
		send_step(step_of(0, 1000, -18000, 32'h0000_0400));
		send_step(step_of(0, 1499, 300, 32'h0000_0500));
		send_step(step_of(0, 1500, -300, 32'h0000_0600));
		send_step(step_of(0, 0, -301, 32'd10292));
		send_step(step_of(9999, 0, 0, 32'd10400));
		send_step(step_of(150, 100, 0, 32'd20600));
		send_step(step_of(0, 100, 0, 32'd20601));
		send_step(step_of(49, 0, 0, 32'd20700));
		send_step(step_of(0, 0, 301, 32'd31200));
		send_step(step_of(0, 0, 0, 32'hFFFF_FFFF));
		send_step(step_of(149, 0, 0, 32'h0000_0010));
		clock_now = 32'h0000_0020;

		repeat (70) send_step(make_step(1'b0));
		drain_cmds();

		reg_vals = '{16'd9999, 16'd9999, 16'd18000, 16'd0, 16'd7, 16'd0, 16'd0, 16'd0};
		load_settings(reg_vals);
		repeat (70) send_step(make_step(1'b0));
		drain_cmds();

		reg_vals = '{16'd0, 16'd0, 16'd0, 16'd18000, 16'd0, 16'd65535, 16'd65535, 16'd18000};
		load_settings(reg_vals);
		repeat (25) send_step(make_step(1'b0));
		drain_cmds();

		reg_vals = '{16'($urandom_range(0, 9999)), 16'($urandom_range(0, 9999)),
			16'($urandom_range(0, 18000)), 16'($urandom_range(0, 18000)),
			16'($urandom_range(1, 7)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 18000))};
		load_settings(reg_vals);
		repeat (80) send_step(make_step(1'b0));
		drain_cmds();

		reg_vals = '{16'd150, 16'd50, 16'd1500, 16'd500, 16'd3, 16'd10000, 16'd1000, 16'd300};
		load_settings(reg_vals);
		repeat (40) send_step(make_step(1'b0));
		while (sb.phase != PH_COMPLETE)
			send_step(make_step(1'b1));
		repeat (4) send_step(make_step(1'b1));
		drain_cmds();
		repeat (10) @(posedge clk);

		if (sb.pending_cmds.size() != 0)
			$display("%0d commands never arrived", sb.pending_cmds.size());
		if (sb.mismatches == 0 && sb.pending_cmds.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
design/scs_pkg.sv
design/scs_front.sv
design/scs_queue.sv
design/scs_back.sv
design/stair_climb_sequencer.sv
verif/stair_climb_sequencer_test.sv
